### rtl/core/bgzf_block_framer_unit_defines.svh
// Assertion macros for the BGZF block framer.
// Included by bgzf_block_framer_unit.sv; no other dependencies.
`ifndef BGZF_BLOCK_FRAMER_UNIT_DEFINES_SVH
`define BGZF_BLOCK_FRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define BGZF_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define BGZF_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
    else $error(msg);

`endif

### rtl/core/bgzf_pkg.sv
// Types and constants for the BGZF block framer.
// No dependencies; used by bgzf_block_framer_unit.
package bgzf_pkg;

  // framer phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SUB    = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_TRAIL  = 3'd3;
  localparam logic [2:0] PH_HALT   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_NORMAL    = 2'd0;
  localparam logic [1:0] KIND_END       = 2'd1;
  localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;
  localparam logic [1:0] KIND_BAD_FLAGS = 2'd3;

  // gzip header bytes checked
  localparam logic [7:0] ID1_BYTE    = 8'h1f;
  localparam logic [7:0] ID2_BYTE    = 8'h8b;
  localparam logic [7:0] METHOD_BYTE = 8'h08;
  localparam logic [7:0] FLAGS_BYTE  = 8'h04;

  // last byte index of each framed section
  localparam logic [3:0] HEADER_LAST = 4'd11;
  localparam logic [3:0] SUB_LAST    = 4'd5;
  localparam logic [3:0] TRAIL_LAST  = 4'd7;

  // header + trailer overhead beyond extra field, less one
  localparam logic [15:0] BLOCK_OVERHEAD = 16'd19;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] modified_time;
    logic [7:0]  extra_flags;
    logic [7:0]  os_id;
    logic [15:0] extra_len;
    logic [15:0] subfield_id;
    logic [15:0] subfield_len;
    logic [15:0] bc_size;
    logic [15:0] payload_length;
    logic [31:0] block_crc;
    logic [31:0] raw_length;
    logic [31:0] total_payload;
  } summary_t;

endpackage

### rtl/core/bgzf_block_framer_unit.sv
// BGZF block framer: splits a byte stream into blocks and reports each one.
// Depends on bgzf_pkg and bgzf_block_framer_unit_defines.svh.
//
//  channel   dir  handshake                      word
//  byte      in   byte_valid / byte_stall        data_byte
//  summary   out  summary_valid / summary_stall  result_kind .. total_payload
//
// One byte per cycle when not stalled: each accepted byte updates the framer
// state in the same edge and, on the last trailer byte or a failed header,
// loads one summary. Summaries pass an output register backed by a one-word
// skid register, so a byte is still taken while a summary waits; byte_stall
// rises only when both hold a word. Reset (rst, synchronous) returns to the
// header phase with zero totals. After an error or the end-marker block every
// accepted byte is dropped until reset.
`include "bgzf_block_framer_unit_defines.svh"

module bgzf_block_framer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        byte_valid,
  output logic        byte_stall,
  input  logic [7:0]  data_byte,
  output logic        summary_valid,
  input  logic        summary_stall,
  output logic [1:0]  result_kind,
  output logic [31:0] modified_time,
  output logic [7:0]  extra_flags,
  output logic [7:0]  os_id,
  output logic [15:0] extra_len,
  output logic [15:0] subfield_id,
  output logic [15:0] subfield_len,
  output logic [15:0] bc_size,
  output logic [15:0] payload_length,
  output logic [31:0] block_crc,
  output logic [31:0] raw_length,
  output logic [31:0] total_payload
);

  // ---------------------------------------------------------------------------
  // Framer state
  // ---------------------------------------------------------------------------
  logic [2:0]  phase, phase_next;
  logic [3:0]  position, position_next;   // byte index within section
  logic [3:0]  magic_seen, magic_seen_next;
  logic [31:0] mtime_reg, mtime_reg_next;
  logic [7:0]  xfl_reg, xfl_reg_next;
  logic [7:0]  os_reg, os_reg_next;
  logic [15:0] xlen_reg, xlen_reg_next;
  logic [15:0] sub_id_reg, sub_id_reg_next;
  logic [15:0] sub_len_reg, sub_len_reg_next;
  logic [15:0] bsize_reg, bsize_reg_next;
  logic [15:0] payload_reg, payload_reg_next;  // payload length of this block
  logic [15:0] skip_left, skip_left_next;
  logic [31:0] crc_reg, crc_reg_next;
  logic [31:0] isize_reg, isize_reg_next;
  logic [31:0] payload_total, payload_total_next;

  logic                accept;
  logic                res_valid;
  logic [1:0]          res_kind;
  logic                res_full;      // block completed, subfield/trailer valid
  bgzf_pkg::summary_t  res;

  // Output register and skid
  logic                out_valid_q;
  bgzf_pkg::summary_t  out_q;
  logic                skid_valid;
  bgzf_pkg::summary_t  skid_q;

  // phase flags for the checks below
  logic                halted;
  logic                skipping;

  assign byte_stall = skid_valid;
  assign accept     = byte_valid && !byte_stall;

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    magic_seen_next    = magic_seen;
    mtime_reg_next     = mtime_reg;
    xfl_reg_next       = xfl_reg;
    os_reg_next        = os_reg;
    xlen_reg_next      = xlen_reg;
    sub_id_reg_next    = sub_id_reg;
    sub_len_reg_next   = sub_len_reg;
    bsize_reg_next     = bsize_reg;
    payload_reg_next   = payload_reg;
    skip_left_next     = skip_left;
    crc_reg_next       = crc_reg;
    isize_reg_next     = isize_reg;
    payload_total_next = payload_total;
    res_valid          = 1'b0;
    res_kind           = bgzf_pkg::KIND_NORMAL;
    res_full           = 1'b0;

    if (accept) begin
      case (phase)
        bgzf_pkg::PH_HEADER: begin
          case (position)
            4'd0: magic_seen_next = {3'b000, data_byte == bgzf_pkg::ID1_BYTE};
            4'd1: magic_seen_next[1] = (data_byte == bgzf_pkg::ID2_BYTE);
            4'd2: magic_seen_next[2] = (data_byte == bgzf_pkg::METHOD_BYTE);
            4'd3: magic_seen_next[3] = (data_byte == bgzf_pkg::FLAGS_BYTE);
            4'd4: mtime_reg_next = {24'd0, data_byte};
            4'd5, 4'd6, 4'd7: mtime_reg_next[{position[1:0], 3'b000} +: 8] = data_byte;
            4'd8: xfl_reg_next = data_byte;
            4'd9: os_reg_next = data_byte;
            4'd10: xlen_reg_next = {8'd0, data_byte};
            default: xlen_reg_next[15:8] = data_byte;
          endcase
          if (position >= bgzf_pkg::HEADER_LAST) begin
            position_next = '0;
            if (magic_seen_next[1:0] != 2'b11) begin
              phase_next = bgzf_pkg::PH_HALT;
              res_valid  = 1'b1;
              res_kind   = bgzf_pkg::KIND_BAD_MAGIC;
            end else if (magic_seen_next[3:2] != 2'b11) begin
              phase_next = bgzf_pkg::PH_HALT;
              res_valid  = 1'b1;
              res_kind   = bgzf_pkg::KIND_BAD_FLAGS;
            end else begin
              phase_next = bgzf_pkg::PH_SUB;
            end
          end else begin
            position_next = position + 4'd1;
          end
        end
        bgzf_pkg::PH_SUB: begin
          case (position)
            4'd0: sub_id_reg_next = {8'd0, data_byte};
            4'd1: sub_id_reg_next[15:8] = data_byte;
            4'd2: sub_len_reg_next = {8'd0, data_byte};
            4'd3: sub_len_reg_next[15:8] = data_byte;
            4'd4: bsize_reg_next = {8'd0, data_byte};
            default: bsize_reg_next[15:8] = data_byte;
          endcase
          if (position >= bgzf_pkg::SUB_LAST) begin
            position_next    = '0;
            payload_reg_next = bsize_reg_next - xlen_reg - bgzf_pkg::BLOCK_OVERHEAD;
            skip_left_next   = payload_reg_next;
            phase_next = (payload_reg_next != 16'd0) ? bgzf_pkg::PH_SKIP
                                                     : bgzf_pkg::PH_TRAIL;
          end else begin
            position_next = position + 4'd1;
          end
        end
        bgzf_pkg::PH_SKIP: begin
          skip_left_next = skip_left - 16'd1;
          if (skip_left_next == 16'd0) begin
            phase_next    = bgzf_pkg::PH_TRAIL;
            position_next = '0;
          end
        end
        bgzf_pkg::PH_TRAIL: begin
          case (position)
            4'd0: crc_reg_next = {24'd0, data_byte};
            4'd1, 4'd2, 4'd3: crc_reg_next[{position[1:0], 3'b000} +: 8] = data_byte;
            4'd4: isize_reg_next = {24'd0, data_byte};
            default: isize_reg_next[{position[1:0], 3'b000} +: 8] = data_byte;
          endcase
          if (position >= bgzf_pkg::TRAIL_LAST) begin
            position_next      = '0;
            payload_total_next = payload_total + {16'd0, payload_reg};
            res_valid          = 1'b1;
            res_full           = 1'b1;
            if (crc_reg_next == 32'd0 && isize_reg_next == 32'd0) begin
              res_kind   = bgzf_pkg::KIND_END;
              phase_next = bgzf_pkg::PH_HALT;
            end else begin
              res_kind   = bgzf_pkg::KIND_NORMAL;
              phase_next = bgzf_pkg::PH_HEADER;
            end
          end else begin
            position_next = position + 4'd1;
          end
        end
        default: begin
          // halted: byte dropped
        end
      endcase
    end
  end

  // Summary word; subfield and trailer fields only on a completed block
  always_comb begin
    res.result_kind     = res_kind;
    res.modified_time   = mtime_reg_next;
    res.extra_flags     = xfl_reg_next;
    res.os_id           = os_reg_next;
    res.extra_len       = xlen_reg_next;
    res.subfield_id     = res_full ? sub_id_reg  : 16'd0;
    res.subfield_len    = res_full ? sub_len_reg : 16'd0;
    res.bc_size         = res_full ? bsize_reg   : 16'd0;
    res.payload_length  = res_full ? payload_reg : 16'd0;
    res.block_crc       = res_full ? crc_reg_next   : 32'd0;
    res.raw_length      = res_full ? isize_reg_next : 32'd0;
    res.total_payload   = payload_total_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= bgzf_pkg::PH_HEADER;
      position      <= '0;
      magic_seen    <= '0;
      mtime_reg     <= '0;
      xfl_reg       <= '0;
      os_reg        <= '0;
      xlen_reg      <= '0;
      sub_id_reg    <= '0;
      sub_len_reg   <= '0;
      bsize_reg     <= '0;
      payload_reg   <= '0;
      skip_left     <= '0;
      crc_reg       <= '0;
      isize_reg     <= '0;
      payload_total <= '0;
    end else begin
      phase         <= phase_next;
      position      <= position_next;
      magic_seen    <= magic_seen_next;
      mtime_reg     <= mtime_reg_next;
      xfl_reg       <= xfl_reg_next;
      os_reg        <= os_reg_next;
      xlen_reg      <= xlen_reg_next;
      sub_id_reg    <= sub_id_reg_next;
      sub_len_reg   <= sub_len_reg_next;
      bsize_reg     <= bsize_reg_next;
      payload_reg   <= payload_reg_next;
      skip_left     <= skip_left_next;
      crc_reg       <= crc_reg_next;
      isize_reg     <= isize_reg_next;
      payload_total <= payload_total_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register + skid. The skid fills only while the output word is held;
  // it then stalls the byte side until the output drains.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (!out_valid_q || !summary_stall) begin
      out_valid_q <= skid_valid || res_valid;
      skid_valid  <= 1'b0;
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_q || !summary_stall) begin
      out_q <= skid_valid ? skid_q : res;
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign summary_valid   = out_valid_q;
  assign result_kind     = out_q.result_kind;
  assign modified_time   = out_q.modified_time;
  assign extra_flags     = out_q.extra_flags;
  assign os_id           = out_q.os_id;
  assign extra_len       = out_q.extra_len;
  assign subfield_id     = out_q.subfield_id;
  assign subfield_len    = out_q.subfield_len;
  assign bc_size         = out_q.bc_size;
  assign payload_length  = out_q.payload_length;
  assign block_crc       = out_q.block_crc;
  assign raw_length      = out_q.raw_length;
  assign total_payload   = out_q.total_payload;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  assign halted   = (phase == bgzf_pkg::PH_HALT);
  assign skipping = (phase == bgzf_pkg::PH_SKIP);

  `BGZF_ASSERT_IMPLY(a_skid_behind_out, clk, rst, skid_valid, out_valid_q, "skid without out")
  `BGZF_ASSERT_NEXT(a_halt_sticks, clk, rst, halted, halted, "halt left without reset")
  `BGZF_ASSERT_IMPLY(a_skip_nonzero, clk, rst, skipping, skip_left != 16'd0, "skip count zero")
  `BGZF_ASSERT_IMPLY(a_result_on_accept, clk, rst, res_valid, accept, "summary without byte")

endmodule
